[design/emsel_pkg.sv]
// Shared types, constants and helper functions for the exponential-mechanism
// split selector. No dependencies; every design file imports this package.
package emsel_pkg;

  // Sizing of the per-node bin row.
  localparam int MAX_BINS = 256;
  localparam int IDX_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = $clog2(MAX_BINS + 1);

  // Field widths.
  localparam int GAIN_W   = 32;
  localparam int RND_W    = 16;
  localparam int BIN_W    = 8;
  localparam int WEIGHT_W = 32;
  localparam int TOTAL_W  = 40;
  localparam int SCALE_W  = 32;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_REG_WEIGHT_SCALE = 1'b0;
  localparam logic [SCALE_W-1:0] WEIGHT_SCALE_RESET = 32'd16777216;

  // Exponential arithmetic constants.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic signed [63:0] X_LIMIT = 64'sh0000_0C00_0000_0000;
  localparam logic [3:0] TAYLOR_TERMS = 4'd10;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  // Top-level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXP,
    ST_THRESH,
    ST_WALK
  } ctrl_state_t;

  // Exponential unit sequencer.
  typedef enum logic [2:0] {
    EX_IDLE,
    EX_RANGE,
    EX_FRAC,
    EX_TMUL,
    EX_TDIV,
    EX_TACC,
    EX_SCALE,
    EX_DONE
  } exp_state_t;

  // Contents of one bin cell.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [GAIN_W-1:0]   gain;
  } cell_t;

  // Reciprocal floor(2^32 / n) for the Taylor term divisors.
  function automatic logic [32:0] recip(input logic [3:0] n);
    logic [32:0] res;
    unique case (n)
      4'd1:    res = 33'h1_0000_0000;
      4'd2:    res = 33'd2147483648;
      4'd3:    res = 33'd1431655765;
      4'd4:    res = 33'd1073741824;
      4'd5:    res = 33'd858993459;
      4'd6:    res = 33'd715827882;
      4'd7:    res = 33'd613566756;
      4'd8:    res = 33'd536870912;
      4'd9:    res = 33'd477218588;
      4'd10:   res = 33'd429496729;
      default: res = '0;
    endcase
    return res;
  endfunction

  // Saturating accumulate of a weight into a 40-bit sum.
  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [WEIGHT_W-1:0] w);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W + 1)'(w);
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

[design/emsel_exp.sv]
// Multi-cycle unit that turns a gain into the weight exp(scale * gain), Q16.16.
// Depends on emsel_pkg for constants, the reciprocal table and the state type.
module emsel_exp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [emsel_pkg::SCALE_W-1:0] scale,
  input  logic [emsel_pkg::GAIN_W-1:0]  gain,
  output logic                          done,
  output logic [emsel_pkg::WEIGHT_W-1:0] weight
);
  import emsel_pkg::*;

  exp_state_t state_r, state_nxt;

  logic signed [63:0] x40_r;
  logic signed [60:0] yprod_r;
  logic signed [5:0]  k_r;
  logic [53:0]        rprod_r;
  logic [30:0]        term_r;
  logic [31:0]        sum_r;
  logic [3:0]         n_r;
  logic [60:0]        tprod_r;
  logic [29:0]        p_r;
  logic [62:0]        mq_r;
  logic [WEIGHT_W-1:0] weight_r;

  logic signed [64:0] xprod;
  logic signed [28:0] x24;
  logic signed [29:0] y24;
  logic [29:0]        r_val;
  logic [29:0]        q0;
  logic [33:0]        rem;
  logic [29:0]        q;
  logic               sat_hi;
  logic               sat_lo;
  logic signed [6:0]  sh;
  logic [32:0]        dbl;
  logic [WEIGHT_W-1:0] scaled;

  // Datapath slices of the registered products.
  assign xprod  = $signed({1'b0, scale}) * $signed(gain);
  assign sat_hi = (x40_r >= X_LIMIT);
  assign sat_lo = (x40_r <= -X_LIMIT);
  assign x24    = x40_r[44:16];
  assign y24    = yprod_r[59:30];
  assign r_val  = rprod_r[53:24];

  // Reciprocal quotient is at most one short; one compare and subtract fixes it.
  assign q0  = mq_r[61:32];
  assign rem = {4'b0, p_r} - (34'(q0) * 34'(n_r));
  assign q   = (rem >= 34'(n_r)) ? q0 + 30'd1 : q0;

  // Final scaling by 2^k into Q16.16.
  assign sh  = 7'sd14 - {k_r[5], k_r};
  assign dbl = {sum_r, 1'b0};
  always_comb begin
    if (k_r >= 6'sd16) begin
      scaled = WEIGHT_MAX;
    end else if (sh < 7'sd0) begin
      scaled = dbl[32] ? WEIGHT_MAX : dbl[31:0];
    end else if (sh >= 7'sd32) begin
      scaled = '0;
    end else begin
      scaled = sum_r >> sh[4:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EX_IDLE:  if (start) state_nxt = EX_RANGE;
      EX_RANGE: state_nxt = (sat_hi || sat_lo) ? EX_DONE : EX_FRAC;
      EX_FRAC:  state_nxt = EX_TMUL;
      EX_TMUL:  state_nxt = EX_TDIV;
      EX_TDIV:  state_nxt = EX_TACC;
      EX_TACC:  state_nxt = (n_r == TAYLOR_TERMS) ? EX_SCALE : EX_TMUL;
      EX_SCALE: state_nxt = EX_DONE;
      EX_DONE:  state_nxt = EX_IDLE;
      default:  state_nxt = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Product and series registers; one multiplier stage per cycle.
  always_ff @(posedge clk) begin
    unique case (state_r)
      EX_IDLE: begin
        if (start) x40_r <= xprod[63:0];
      end
      EX_RANGE: begin
        yprod_r <= x24 * $signed({1'b0, LOG2E_Q30});
        if (sat_hi) weight_r <= WEIGHT_MAX;
        else if (sat_lo) weight_r <= '0;
      end
      EX_FRAC: begin
        k_r     <= y24[29:24];
        rprod_r <= 54'(y24[23:0]) * 54'(LN2_Q30);
        term_r  <= ONE_Q30;
        sum_r   <= 32'(ONE_Q30);
        n_r     <= 4'd1;
      end
      EX_TMUL: begin
        tprod_r <= 61'(term_r) * 61'(r_val);
      end
      EX_TDIV: begin
        p_r  <= tprod_r[59:30];
        mq_r <= 63'(tprod_r[59:30]) * 63'(recip(n_r));
      end
      EX_TACC: begin
        term_r <= 31'(q);
        sum_r  <= sum_r + 32'(q);
        n_r    <= n_r + 4'd1;
      end
      EX_SCALE: begin
        weight_r <= scaled;
      end
      EX_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign done   = (state_r == EX_DONE);
  assign weight = weight_r;

endmodule

[design/emsel_cell.sv]
// One cell of the bin row: holds a weight and a gain, loads from the front end
// and hands its contents to the lower neighbour while the row is walked.
// Depends on emsel_pkg for the cell type.
module emsel_cell (
  input  logic             clk,
  input  logic             load_en,
  input  emsel_pkg::cell_t load_data,
  input  logic             shift_en,
  input  emsel_pkg::cell_t next_data,
  output emsel_pkg::cell_t data
);
  import emsel_pkg::*;

  cell_t data_r;

  // Load and shift never coincide: loading happens only outside the walk.
  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= load_data;
    end else if (shift_en) begin
      data_r <= next_data;
    end
  end

  assign data = data_r;

endmodule

[design/exponential_mechanism_split_select_core.sv]
// Top level of the exponential-mechanism split selector: stream ports, APB
// register, the weight unit emsel_exp and a row of emsel_cell bin cells.
// Depends on emsel_pkg, emsel_exp and emsel_cell.
//
//   Port group  Direction  Beat contents
//   in_*        slave      tdata: gain, random_fraction; tlast: last_bin
//   out_*       master     tdata: chosen_bin, chosen_gain
//   cfg_*       APB slave  weight_scale at byte address 0
//
// Each accepted beat with room in the row runs through the exponential unit: two
// multiply stages, a multiply, divide and accumulate step for each of ten Taylor
// terms, a scaling step and a done step; then the core goes back to idle for the next beat.
// Saturated weights skip the series; beats past a full row do not enter the unit.
// After the last bin a threshold step and a walk through the cell row follow, one
// bin per cycle up to and including the chosen one. One beat is worked on at a time.
// A stalled result waits in the output register and the next beat is still taken;
// a later walk holds at its end until that register is free.
// Reset is synchronous and clears the control state; cells need none.
module exponential_mechanism_split_select_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [47:0]                  in_tdata,  // gain[31:0], random_fraction[47:32]
  input  logic                         in_tlast,  // last_bin
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata, // chosen_bin[7:0], chosen_gain[39:8]
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [emsel_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [emsel_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [emsel_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import emsel_pkg::*;

  ctrl_state_t state_r, state_nxt;

  logic [SCALE_W-1:0]  scale_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [RND_W-1:0]    rnd_r;
  logic                last_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    j_r;
  logic [TOTAL_W-1:0]  partial_r;
  logic [55:0]         thresh_r;
  logic                out_valid_r;
  logic [39:0]         out_data_r;

  logic                in_beat;
  logic                cfg_wr;
  logic                exp_start;
  logic                exp_done;
  logic [WEIGHT_W-1:0] exp_weight;
  logic                room;
  cell_t               new_cell;
  cell_t               cells [MAX_BINS];
  logic                shift_en;
  logic [TOTAL_W-1:0]  partial_nxt;
  logic                hit;
  logic                walk_end;
  logic                out_free;
  logic                emit;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_REG_WEIGHT_SCALE) ? scale_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= WEIGHT_SCALE_RESET;
    end else if (cfg_wr && cfg_paddr[2] == CFG_REG_WEIGHT_SCALE) begin
      scale_r <= cfg_pwdata;
    end
  end

  // Input handshake and capture.
  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign room      = (count_r < CNT_W'(MAX_BINS));
  assign exp_start = in_beat && room;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      gain_r <= in_tdata[31:0];
      rnd_r  <= in_tdata[47:32];
      last_r <= in_tlast;
    end
  end

  emsel_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (exp_start),
    .scale  (scale_r),
    .gain   (in_tdata[31:0]),
    .done   (exp_done),
    .weight (exp_weight)
  );

  // Row of bin cells: loaded at the fill position, walked from cell zero.
  assign new_cell.weight = exp_weight;
  assign new_cell.gain   = gain_r;

  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    cell_t next_c;
    if (i == MAX_BINS - 1) begin : g_end
      assign next_c = '0;
    end else begin : g_mid
      assign next_c = cells[i+1];
    end
    emsel_cell u_cell (
      .clk       (clk),
      .load_en   (exp_done && count_r == CNT_W'(i)),
      .load_data (new_cell),
      .shift_en  (shift_en),
      .next_data (next_c),
      .data      (cells[i])
    );
  end

  // Selection walk over the head cell.
  assign partial_nxt = sat_add(partial_r, cells[0].weight);
  assign hit         = ({partial_nxt, 16'b0} > thresh_r);
  assign walk_end    = hit || (j_r == IDX_W'(count_r - CNT_W'(1)));
  assign out_free    = !out_valid_r || out_tready;
  assign emit        = (state_r == ST_WALK) && walk_end && out_free;
  assign shift_en    = (state_r == ST_WALK) && !walk_end;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (room) state_nxt = ST_EXP;
          else if (in_tlast) state_nxt = ST_THRESH;
        end
      end
      ST_EXP: begin
        if (exp_done) state_nxt = last_r ? ST_THRESH : ST_IDLE;
      end
      ST_THRESH: state_nxt = ST_WALK;
      ST_WALK: begin
        if (emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Node bookkeeping: fill count and running total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (exp_done) begin
      count_r <= count_r + CNT_W'(1);
      total_r <= sat_add(total_r, exp_weight);
    end else if (emit) begin
      count_r <= '0;
      total_r <= '0;
    end
  end

  // Threshold and walk registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_THRESH) begin
      thresh_r  <= 56'(rnd_r) * 56'(total_r);
      j_r       <= '0;
      partial_r <= '0;
    end else if (shift_en) begin
      j_r       <= j_r + IDX_W'(1);
      partial_r <= partial_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {cells[0].gain, BIN_W'(j_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BINS))
    else $error("bin count beyond row length");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (count_r != '0))
    else $error("walk over an empty node");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (CNT_W'(j_r) < count_r))
    else $error("walk index past the stored bins");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && count_r == '0 && total_r == '0))
    else $error("result not posted or node not cleared");

  a_no_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !exp_done)
    else $error("cell load during walk");
`endif

endmodule
